>>> hw/rtl/quaternion_arithmetic_unit_macros.svh
// assertion macros for the quaternion arithmetic unit
`ifndef QUATERNION_ARITHMETIC_UNIT_MACROS_SVH
`define QUATERNION_ARITHMETIC_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define QAU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define QAU_ASSERT_DLY(label, ante, n, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error(msg);
`else
`define QAU_ASSERT_IMP(label, ante, cons, msg)
`define QAU_ASSERT_DLY(label, ante, n, cons, msg)
`endif
`endif

>>> hw/rtl/qau_pkg.sv
// shared types, constants and helper functions of the quaternion unit
package qau_pkg;

	localparam int FRAC_BITS = 28;
	localparam int SINCOS_ITERATIONS = 28;
	localparam int CORDIC_N = (SINCOS_ITERATIONS < 32) ? SINCOS_ITERATIONS : 32;

	localparam logic [2:0] MODE_MUL  = 3'd0;
	localparam logic [2:0] MODE_CONJ = 3'd1;
	localparam logic [2:0] MODE_NORM = 3'd2;
	localparam logic [2:0] MODE_DOT  = 3'd3;
	localparam logic [2:0] MODE_ROT  = 3'd4;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] a_w;
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_w;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] rotation_angle;
	} op_t;

	typedef struct packed {
		logic signed [31:0] r_w;
		logic signed [31:0] r_x;
		logic signed [31:0] r_y;
		logic signed [31:0] r_z;
		logic signed [31:0] dot_value;
		logic               too_short;
		logic               saturated;
	} res_t;

	// saturation to 32 bits from a wide signed value
	localparam int SAT_W = 72;
	localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(64'sh7fff_ffff);
	localparam logic signed [SAT_W-1:0] SAT_LO = ~SAT_HI;

	typedef struct packed {
		logic               flag;
		logic signed [31:0] val;
	} sat_t;

	function automatic sat_t sat32(input logic signed [SAT_W-1:0] x);
		sat_t r;
		r.flag = 1'b1;
		if (x > SAT_HI) begin
			r.val = 32'sh7fff_ffff;
		end else if (x < SAT_LO) begin
			r.val = 32'sh8000_0000;
		end else begin
			r.flag = 1'b0;
			r.val  = x[31:0];
		end
		return r;
	endfunction

	// angle reduction, Q.31 half angle
	localparam logic [32:0] PI_Q31         = 33'd6746518852;
	localparam logic [32:0] HALF_PI_Q31    = 33'd3373259426;
	localparam logic [31:0] QUARTER_PI_Q31 = 32'd1686629713;
	localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
	localparam int ANG_W  = 62 - FRAC_BITS;
	localparam int RED_W  = ANG_W + 1;
	localparam int QROT_W = RED_W - 32;
	localparam int CORD_W = 35;
	localparam int PR_W   = CORD_W + 32;

	// normalize divider
	localparam int NQ_W  = FRAC_BITS + 2;
	localparam int DIV_W = FRAC_BITS + 34;

	localparam int LAT_MAC = 3;
	localparam int LAT_ROT = CORDIC_N + 4;
	localparam int LAT_NRM = NQ_W + 40;
	localparam int LAT_OUT = LAT_NRM + 1;

	// atan(2^-i) in Q.31 from the integer power series, evaluated at elaboration
	function automatic logic [31:0] atan_q31(input int i);
		logic signed [63:0] sum;
		logic [63:0]        term;
		int                 k;
		sum = '0;
		if (i == 0) begin
			return QUARTER_PI_Q31;
		end
		for (k = 0; i * (2 * k + 1) <= 62; k++) begin
			term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
			if (k % 2 == 1) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		return 32'((sum + 64'sd1073741824) >>> 31);
	endfunction

endpackage

>>> hw/rtl/qau_mac.sv
// hamilton product and dot product pipeline
module qau_mac (
	input  logic          clk,
	input  qau_pkg::op_t  op,
	output qau_pkg::res_t mul_res,
	output qau_pkg::res_t dot_res
);
	import qau_pkg::*;

	logic signed [31:0] a [4];
	logic signed [31:0] b [4];
	logic signed [63:0] p_s1 [4][4];
	logic signed [65:0] sw_s2, sx_s2, sy_s2, sz_s2, sd_s2;
	sat_t               rw, rx, ry, rz, rd;
	res_t               mul_s3, dot_s3;

	assign a[0] = op.a_w;
	assign a[1] = op.a_x;
	assign a[2] = op.a_y;
	assign a[3] = op.a_z;
	assign b[0] = op.b_w;
	assign b[1] = op.b_x;
	assign b[2] = op.b_y;
	assign b[3] = op.b_z;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				p_s1[i][j] <= a[i] * b[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		sw_s2 <= 66'(p_s1[0][0]) - 66'(p_s1[1][1]) - 66'(p_s1[2][2]) - 66'(p_s1[3][3]);
		sx_s2 <= 66'(p_s1[0][1]) + 66'(p_s1[1][0]) + 66'(p_s1[2][3]) - 66'(p_s1[3][2]);
		sy_s2 <= 66'(p_s1[0][2]) + 66'(p_s1[2][0]) + 66'(p_s1[3][1]) - 66'(p_s1[1][3]);
		sz_s2 <= 66'(p_s1[0][3]) + 66'(p_s1[3][0]) + 66'(p_s1[1][2]) - 66'(p_s1[2][1]);
		sd_s2 <= 66'(p_s1[0][0]) + 66'(p_s1[1][1]) + 66'(p_s1[2][2]) + 66'(p_s1[3][3]);
	end

	// round to nearest, ties up, then clip
	function automatic sat_t rnd(input logic signed [65:0] s);
		logic signed [65:0] t;
		t = (s + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		return sat32(SAT_W'(t));
	endfunction

	assign rw = rnd(sw_s2);
	assign rx = rnd(sx_s2);
	assign ry = rnd(sy_s2);
	assign rz = rnd(sz_s2);
	assign rd = rnd(sd_s2);

	always_ff @(posedge clk) begin
		mul_s3.r_w       <= rw.val;
		mul_s3.r_x       <= rx.val;
		mul_s3.r_y       <= ry.val;
		mul_s3.r_z       <= rz.val;
		mul_s3.dot_value <= '0;
		mul_s3.too_short <= 1'b0;
		mul_s3.saturated <= rw.flag | rx.flag | ry.flag | rz.flag;
		dot_s3.r_w       <= '0;
		dot_s3.r_x       <= '0;
		dot_s3.r_y       <= '0;
		dot_s3.r_z       <= '0;
		dot_s3.dot_value <= rd.val;
		dot_s3.too_short <= 1'b0;
		dot_s3.saturated <= rd.flag;
	end

	assign mul_res = mul_s3;
	assign dot_res = dot_s3;

endmodule

>>> hw/rtl/qau_rot.sv
// axis-angle to rotation quaternion: angle reduction, cordic, axis scaling
module qau_rot (
	input  logic          clk,
	input  qau_pkg::op_t  op,
	output qau_pkg::res_t res
);
	import qau_pkg::*;

	logic signed [ANG_W-1:0]  hq;
	logic [ANG_W-1:0]         mag_s1;
	logic                     neg_s1;
	logic signed [31:0]       ax_s1 [3];
	logic [RED_W-1:0]         rem;
	logic [QROT_W-1:0]        qb;
	logic signed [CORD_W-1:0] rr;

	logic signed [CORD_W-1:0] cx_s [CORDIC_N+1];
	logic signed [CORD_W-1:0] cy_s [CORDIC_N+1];
	logic signed [CORD_W-1:0] cz_s [CORDIC_N+1];
	logic                     qodd_s [CORDIC_N+1];
	logic signed [31:0]       ax_s [CORDIC_N+1][3];

	logic signed [CORD_W-1:0] cc, ss;
	logic signed [PR_W-1:0]   pr_p [3];
	logic signed [CORD_W-1:0] cw_p;
	sat_t                     sw, sv [3];
	res_t                     res_f;

	localparam logic signed [CORD_W-1:0] RW_RND = (CORD_W'(1) <<< (30 - FRAC_BITS)) >>> 1;
	localparam logic signed [PR_W-1:0]   PR_RND = PR_W'(1) <<< 29;

	// half angle in Q.31
	assign hq = ANG_W'(op.rotation_angle) <<< (30 - FRAC_BITS);

	always_ff @(posedge clk) begin
		mag_s1   <= hq[ANG_W-1] ? ANG_W'(-hq) : ANG_W'(hq);
		neg_s1   <= hq[ANG_W-1];
		ax_s1[0] <= op.a_x;
		ax_s1[1] <= op.a_y;
		ax_s1[2] <= op.a_z;
	end

	// remove the nearest multiple of pi
	always_comb begin
		rem = RED_W'(mag_s1) + RED_W'(HALF_PI_Q31);
		qb  = '0;
		for (int j = QROT_W - 1; j >= 0; j--) begin
			if (rem >= (RED_W'(PI_Q31) << j)) begin
				rem   = rem - (RED_W'(PI_Q31) << j);
				qb[j] = 1'b1;
			end
		end
		rr = CORD_W'($signed({1'b0, rem[32:0]})) - CORD_W'($signed({1'b0, HALF_PI_Q31}));
		if (neg_s1) begin
			rr = -rr;
		end
	end

	always_ff @(posedge clk) begin
		cx_s[0]   <= CORD_W'(CORDIC_GAIN_Q30);
		cy_s[0]   <= '0;
		cz_s[0]   <= rr;
		qodd_s[0] <= qb[0];
		ax_s[0]   <= ax_s1;
	end

	for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
		localparam logic signed [CORD_W-1:0] ATAN_I = CORD_W'(atan_q31(i));
		always_ff @(posedge clk) begin
			if (cz_s[i] >= 0) begin
				cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
				cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
				cz_s[i+1] <= cz_s[i] - ATAN_I;
			end else begin
				cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
				cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
				cz_s[i+1] <= cz_s[i] + ATAN_I;
			end
			qodd_s[i+1] <= qodd_s[i];
			ax_s[i+1]   <= ax_s[i];
		end
	end

	// odd multiple of pi flips both
	assign cc = qodd_s[CORDIC_N] ? -cx_s[CORDIC_N] : cx_s[CORDIC_N];
	assign ss = qodd_s[CORDIC_N] ? -cy_s[CORDIC_N] : cy_s[CORDIC_N];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			pr_p[k] <= ax_s[CORDIC_N][k] * ss;
		end
		cw_p <= cc;
	end

	assign sw = sat32(SAT_W'((cw_p + RW_RND) >>> (30 - FRAC_BITS)));
	for (genvar k = 0; k < 3; k++) begin : g_axis
		assign sv[k] = sat32(SAT_W'((pr_p[k] + PR_RND) >>> 30));
	end

	always_ff @(posedge clk) begin
		res_f.r_w       <= sw.val;
		res_f.r_x       <= sv[0].val;
		res_f.r_y       <= sv[1].val;
		res_f.r_z       <= sv[2].val;
		res_f.dot_value <= '0;
		res_f.too_short <= 1'b0;
		res_f.saturated <= sw.flag | sv[0].flag | sv[1].flag | sv[2].flag;
	end

	assign res = res_f;

endmodule

>>> hw/rtl/qau_nrm.sv
// normalize pipeline: scaling, sum of squares, square root, four dividers
module qau_nrm (
	input  logic          clk,
	input  qau_pkg::op_t  op,
	output qau_pkg::res_t res
);
	import qau_pkg::*;

	typedef struct packed {
		logic [3:0][31:0] v;
		logic [3:0]       neg;
		logic             zero;
	} nrm_trav_t;

	logic signed [31:0] a [4];
	nrm_trav_t          tr_s1, tr_s2, tr_s3, tr_s4, tr_s5;
	logic [31:0]        mx;
	logic [31:0]        mx_s2;
	logic [4:0]         k;
	logic [4:0]         k_s3;
	logic [63:0]        sq_s5 [4];

	logic [63:0]        sr_s [33];
	logic [31:0]        rt_s [33];
	nrm_trav_t          tv_s [33];

	logic [DIV_W-1:0]   dr_s [NQ_W+1][4];
	logic [NQ_W-1:0]    dq_s [NQ_W+1][4];
	logic [31:0]        dh_s [NQ_W+1];
	logic [3:0]         dn_s [NQ_W+1];
	logic               dz_s [NQ_W+1];

	sat_t               sv [4];
	res_t               res_f;

	assign a[0] = op.a_w;
	assign a[1] = op.a_x;
	assign a[2] = op.a_y;
	assign a[3] = op.a_z;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			tr_s1.v[i]   <= a[i][31] ? 32'(-a[i]) : 32'(a[i]);
			tr_s1.neg[i] <= a[i][31];
		end
		tr_s1.zero <= 1'b0;
	end

	always_comb begin
		mx = tr_s1.v[0];
		for (int i = 1; i < 4; i++) begin
			if (tr_s1.v[i] > mx) begin
				mx = tr_s1.v[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		tr_s2.v    <= tr_s1.v;
		tr_s2.neg  <= tr_s1.neg;
		tr_s2.zero <= (mx == '0);
		mx_s2      <= mx;
	end

	// shift that brings the largest magnitude to 2^30 or above
	always_comb begin
		k = '0;
		for (int b = 0; b <= 30; b++) begin
			if (mx_s2[b]) begin
				k = 5'(30 - b);
			end
		end
	end

	always_ff @(posedge clk) begin
		tr_s3 <= tr_s2;
		k_s3  <= k;
	end

	always_ff @(posedge clk) begin
		tr_s4.neg  <= tr_s3.neg;
		tr_s4.zero <= tr_s3.zero;
		for (int i = 0; i < 4; i++) begin
			tr_s4.v[i] <= tr_s3.v[i] << k_s3;
		end
	end

	always_ff @(posedge clk) begin
		tr_s5 <= tr_s4;
		for (int i = 0; i < 4; i++) begin
			sq_s5[i] <= 64'(tr_s4.v[i]) * 64'(tr_s4.v[i]);
		end
	end

	always_ff @(posedge clk) begin
		sr_s[0] <= 64'((66'(sq_s5[0]) + 66'(sq_s5[1]) + 66'(sq_s5[2]) + 66'(sq_s5[3])) >> 2);
		rt_s[0] <= '0;
		tv_s[0] <= tr_s5;
	end

	// square root, one result bit per stage
	for (genvar t = 0; t < 32; t++) begin : g_sqrt
		localparam int J = 31 - t;
		logic [64:0] trial;
		assign trial = ({33'd0, rt_s[t]} << (J + 1)) + (65'd1 << (2 * J));
		always_ff @(posedge clk) begin
			if ({1'b0, sr_s[t]} >= trial) begin
				sr_s[t+1] <= sr_s[t] - trial[63:0];
				rt_s[t+1] <= rt_s[t] | (32'd1 << J);
			end else begin
				sr_s[t+1] <= sr_s[t];
				rt_s[t+1] <= rt_s[t];
			end
			tv_s[t+1] <= tv_s[t];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			dr_s[0][i] <= (DIV_W'(tv_s[32].v[i]) << (FRAC_BITS - 1)) + DIV_W'(rt_s[32] >> 1);
			dq_s[0][i] <= '0;
		end
		dh_s[0] <= rt_s[32];
		dn_s[0] <= tv_s[32].neg;
		dz_s[0] <= tv_s[32].zero;
	end

	// restoring division, one quotient bit per stage in each lane
	for (genvar t = 0; t < NQ_W; t++) begin : g_div
		localparam int J = NQ_W - 1 - t;
		logic [DIV_W-1:0] dvs;
		assign dvs = DIV_W'(dh_s[t]) << J;
		always_ff @(posedge clk) begin
			for (int i = 0; i < 4; i++) begin
				if (dr_s[t][i] >= dvs) begin
					dr_s[t+1][i] <= dr_s[t][i] - dvs;
					dq_s[t+1][i] <= dq_s[t][i] | (NQ_W'(1) << J);
				end else begin
					dr_s[t+1][i] <= dr_s[t][i];
					dq_s[t+1][i] <= dq_s[t][i];
				end
			end
			dh_s[t+1] <= dh_s[t];
			dn_s[t+1] <= dn_s[t];
			dz_s[t+1] <= dz_s[t];
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_out
		logic signed [SAT_W-1:0] qv;
		assign qv    = SAT_W'($signed({1'b0, dq_s[NQ_W][i]}));
		assign sv[i] = sat32(dn_s[NQ_W][i] ? -qv : qv);
	end

	always_ff @(posedge clk) begin
		res_f.dot_value <= '0;
		if (dz_s[NQ_W]) begin
			res_f.r_w       <= '0;
			res_f.r_x       <= '0;
			res_f.r_y       <= '0;
			res_f.r_z       <= '0;
			res_f.too_short <= 1'b1;
			res_f.saturated <= 1'b0;
		end else begin
			res_f.r_w       <= sv[0].val;
			res_f.r_x       <= sv[1].val;
			res_f.r_y       <= sv[2].val;
			res_f.r_z       <= sv[3].val;
			res_f.too_short <= 1'b0;
			res_f.saturated <= sv[0].flag | sv[1].flag | sv[2].flag | sv[3].flag;
		end
	end

	assign res = res_f;

endmodule

>>> hw/rtl/quaternion_arithmetic_unit.sv
// top level of the quaternion arithmetic unit
//
// usage
//   input channel: drive operands and pulse start; an item is taken at every
//   clock edge where start is high and busy is low. busy is held low, so an
//   item may be issued in every cycle, back to back, with no gaps
//   result channel: done is high for exactly one cycle with the item's result
//   on result; the receiver must take it then, it cannot hold results off
//   latency: LAT_OUT = FRAC_BITS + 43 cycles (71 at Q3.28) from start to done,
//   the same for every mode; results come out in issue order
//   throughput: one item per cycle
//   the latency is set by the normalize path: a 32-stage square root with one
//   result bit per stage, then four dividers with one quotient bit per stage;
//   every other mode is delayed to line up with it
//   axis-angle uses a cordic with one iteration per stage
//   reset: arst_n clears all valid bits; items in flight are dropped and no
//   done pulse follows for them. no clearing pass is needed
`include "quaternion_arithmetic_unit_macros.svh"
module quaternion_arithmetic_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  qau_pkg::op_t  operands,
	output logic          done,
	output qau_pkg::res_t result
);
	import qau_pkg::*;

	localparam int MAC_DLY = LAT_NRM - LAT_MAC;
	localparam int ROT_DLY = LAT_NRM - LAT_ROT;

	logic             acc;
	logic [LAT_NRM:1] vld_s;
	logic [2:0]       md_s [1:LAT_NRM];

	res_t             mul_res, dot_res, mac_sel, rot_res, nrm_res, cj;
	res_t             dmac_s [1:MAC_DLY];
	res_t             drot_s [1:ROT_DLY];
	res_t             dcj_s [1:LAT_NRM];
	sat_t             nx, ny, nz;

	logic             done_q;
	res_t             result_q;

	// fully pipelined, never stalls the sender
	assign busy = 1'b0;
	assign acc  = start && !busy;

	// item valid travels alongside the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s  <= '0;
			done_q <= 1'b0;
		end else begin
			vld_s  <= {vld_s[LAT_NRM-1:1], acc};
			done_q <= vld_s[LAT_NRM];
		end
	end

	// mode code follows the item to pick the right unit at each tap
	always_ff @(posedge clk) begin
		md_s[1] <= operands.mode;
		for (int i = 2; i <= LAT_NRM; i++) begin
			md_s[i] <= md_s[i-1];
		end
	end

	qau_mac u_mac (
		.clk     (clk),
		.op      (operands),
		.mul_res (mul_res),
		.dot_res (dot_res)
	);

	qau_rot u_rot (
		.clk (clk),
		.op  (operands),
		.res (rot_res)
	);

	qau_nrm u_nrm (
		.clk (clk),
		.op  (operands),
		.res (nrm_res)
	);

	// conjugate needs only a negate and clip
	assign nx = sat32(-(SAT_W'(operands.a_x)));
	assign ny = sat32(-(SAT_W'(operands.a_y)));
	assign nz = sat32(-(SAT_W'(operands.a_z)));

	always_comb begin
		cj           = '0;
		cj.r_w       = operands.a_w;
		cj.r_x       = nx.val;
		cj.r_y       = ny.val;
		cj.r_z       = nz.val;
		cj.saturated = nx.flag | ny.flag | nz.flag;
	end

	assign mac_sel = (md_s[LAT_MAC] == MODE_DOT) ? dot_res : mul_res;

	// align the shorter units with the normalize path
	always_ff @(posedge clk) begin
		dmac_s[1] <= mac_sel;
		for (int i = 2; i <= MAC_DLY; i++) begin
			dmac_s[i] <= dmac_s[i-1];
		end
		drot_s[1] <= rot_res;
		for (int i = 2; i <= ROT_DLY; i++) begin
			drot_s[i] <= drot_s[i-1];
		end
		dcj_s[1] <= cj;
		for (int i = 2; i <= LAT_NRM; i++) begin
			dcj_s[i] <= dcj_s[i-1];
		end
	end

	// output register; unknown modes give an all-zero result
	always_ff @(posedge clk) begin
		case (md_s[LAT_NRM]) inside
			MODE_MUL, MODE_DOT: result_q <= dmac_s[MAC_DLY];
			MODE_CONJ:          result_q <= dcj_s[LAT_NRM];
			MODE_NORM:          result_q <= nrm_res;
			MODE_ROT:           result_q <= drot_s[ROT_DLY];
			default:            result_q <= '0;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

	`QAU_ASSERT_DLY(a_lat, acc, LAT_OUT, done, "accepted item gave no result in time")
	`QAU_ASSERT_IMP(a_src, done, $past(acc, LAT_OUT), "result without a matching item")
	`QAU_ASSERT_IMP(a_short, done && result.too_short,
		result.r_w == 0 && result.r_x == 0 && result.r_y == 0 && result.r_z == 0
		&& !result.saturated, "short vector result not cleared")
	`QAU_ASSERT_IMP(a_dot, done && result.dot_value != 0,
		result.r_w == 0 && result.r_x == 0 && result.r_y == 0 && result.r_z == 0
		&& !result.too_short, "dot result mixed with quaternion result")

endmodule
